>>> src/mspt_pkg.sv
// mspt_pkg: shared constants and controller command type for the
// min-score polygon triangulation block; no dependencies
package mspt_pkg;

	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_VALUE_BITS   = 8;
	localparam int VERTEX_W         = 8;
	localparam int SCORE_W          = 32;

	// controller to datapath commands
	typedef struct packed {
		logic store_we;
		logic cap_vi;
		logic mul_en;
		logic issue;
		logic first;
		logic adj_ik;
		logic adj_kj;
		logic tbl_we;
		logic score_load;
		logic score_zero;
	} cmd_t;

endpackage

>>> src/mspt_if.sv
// mspt_in_if / mspt_out_if: valid-ready channels for vertex and result transactions
// depends on mspt_pkg
interface mspt_in_if;
	import mspt_pkg::*;

	logic                valid;
	logic                ready;
	logic [VERTEX_W-1:0] vertex_value;
	logic                last;

	modport source(output valid, output vertex_value, output last, input ready);
	modport sink(input valid, input vertex_value, input last, output ready);
endinterface

interface mspt_out_if;
	import mspt_pkg::*;

	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] score;
	logic               too_many;

	modport source(output valid, output score, output too_many, input ready);
	modport sink(input valid, input score, input too_many, output ready);
endinterface

>>> src/mspt_datapath.sv
// mspt_datapath: vertex store, interval table, multiply / add / min pipeline
// depends on mspt_pkg
module mspt_datapath #(
	parameter int MAX_VERTICES = mspt_pkg::DEF_MAX_VERTICES,
	parameter int VALUE_BITS   = mspt_pkg::DEF_VALUE_BITS,
	localparam int AW          = $clog2(MAX_VERTICES)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mspt_pkg::cmd_t                     cmd,
	input  logic [mspt_pkg::VERTEX_W-1:0]      vertex_value,
	input  logic [AW-1:0]                      wr_idx,
	input  logic [AW-1:0]                      rd_idx,
	input  logic [AW-1:0]                      idx_i,
	input  logic [AW-1:0]                      idx_j,
	input  logic [AW-1:0]                      idx_k,
	output logic [mspt_pkg::SCORE_W-1:0]       score
);
	import mspt_pkg::*;

	localparam int PW  = 2 * VALUE_BITS;
	localparam int RW  = 3 * VALUE_BITS;
	localparam int CW  = 3 * VALUE_BITS + AW;
	localparam int TD  = MAX_VERTICES * MAX_VERTICES;
	localparam int TAW = $clog2(TD);
	localparam int EW  = CW + SCORE_W;

	logic [VALUE_BITS-1:0] vmem [MAX_VERTICES];
	logic [CW-1:0]         tmem [TD];

	logic [VALUE_BITS-1:0] vdat_q;
	logic [VALUE_BITS-1:0] vi_q;
	logic [PW-1:0]         vij_q;
	logic [CW-1:0]         tik_s1, tkj_s1;
	logic                  issue_s1, first_s1, adj_ik_s1, adj_kj_s1;
	logic [RW-1:0]         prod_s2;
	logic [CW-1:0]         part_s2;
	logic                  valid_s2, first_s2;
	logic [CW-1:0]         best_q;
	logic [SCORE_W-1:0]    score_q;

	logic [TAW-1:0] addr_ik, addr_kj, addr_ij;
	logic [RW-1:0]  prod_w;
	logic [CW-1:0]  cand;
	logic [EW-1:0]  best_ext;
	logic           sat;

	assign addr_ik = TAW'(idx_i) * TAW'(MAX_VERTICES) + TAW'(idx_k);
	assign addr_kj = TAW'(idx_k) * TAW'(MAX_VERTICES) + TAW'(idx_j);
	assign addr_ij = TAW'(idx_i) * TAW'(MAX_VERTICES) + TAW'(idx_j);

	// vertex store, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.store_we) begin
			vmem[wr_idx] <= VALUE_BITS'(vertex_value);
		end
		vdat_q <= vmem[rd_idx];
	end

	// interval table, one write and two registered reads
	always_ff @(posedge clk) begin
		if (cmd.tbl_we) begin
			tmem[addr_ij] <= best_q;
		end
		tik_s1 <= tmem[addr_ik];
		tkj_s1 <= tmem[addr_kj];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_vi) begin
			vi_q <= vdat_q;
		end
		if (cmd.mul_en) begin
			vij_q <= PW'(vi_q) * PW'(vdat_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
			valid_s2 <= issue_s1;
		end
	end

	assign prod_w = RW'(vij_q) * RW'(vdat_q);

	always_ff @(posedge clk) begin
		first_s1  <= cmd.first;
		adj_ik_s1 <= cmd.adj_ik;
		adj_kj_s1 <= cmd.adj_kj;
		first_s2  <= first_s1;
		prod_s2   <= prod_w;
		// adjacent pairs hold zero and are never stored
		part_s2   <= (adj_ik_s1 ? '0 : tik_s1) + (adj_kj_s1 ? '0 : tkj_s1);
	end

	assign cand = CW'(prod_s2) + part_s2;

	always_ff @(posedge clk) begin
		if (valid_s2 && (first_s2 || cand < best_q)) begin
			best_q <= cand;
		end
	end

	assign best_ext = EW'(best_q);
	assign sat      = |best_ext[EW-1:SCORE_W];

	always_ff @(posedge clk) begin
		if (cmd.score_zero) begin
			score_q <= '0;
		end else if (cmd.score_load) begin
			score_q <= sat ? '1 : best_ext[SCORE_W-1:0];
		end
	end

	assign score = score_q;

endmodule

>>> src/mspt_ctrl.sv
// mspt_ctrl: load and interval sweep sequencer, result handshake
// depends on mspt_pkg
module mspt_ctrl #(
	parameter int MAX_VERTICES = mspt_pkg::DEF_MAX_VERTICES,
	localparam int AW          = $clog2(MAX_VERTICES)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_last,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           too_many,
	output mspt_pkg::cmd_t cmd,
	output logic [AW-1:0]  wr_idx,
	output logic [AW-1:0]  rd_idx,
	output logic [AW-1:0]  idx_i,
	output logic [AW-1:0]  idx_j,
	output logic [AW-1:0]  idx_k
);
	import mspt_pkg::*;

	localparam int NW = $clog2(MAX_VERTICES + 1);

	typedef enum logic [3:0] {
		S_LOAD, S_RDI, S_RDJ, S_MULT, S_KLOOP, S_DRAIN1, S_DRAIN2, S_WRITE, S_DONE
	} state_t;

	state_t        state_q;
	logic [NW-1:0] count_q;
	logic          ovf_q;
	logic [AW-1:0] i_q, j_q, k_q, nlast_q;
	logic          out_valid_q, too_many_q;

	logic          out_free, acc, room, res_set;
	logic [NW-1:0] n_new;
	logic          k_lo, k_hi;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_LOAD) && out_free;
	assign acc      = in_valid && in_ready;
	assign room     = count_q < NW'(MAX_VERTICES);
	assign n_new    = count_q + NW'(room);
	assign k_lo     = k_q == AW'(i_q + 1'b1);
	assign k_hi     = k_q == AW'(j_q - 1'b1);
	// a new result enters the output register
	assign res_set  = cmd.score_zero || cmd.score_load;

	always_comb begin
		cmd            = '0;
		cmd.store_we   = acc && room;
		cmd.score_zero = acc && in_last && (n_new < NW'(3));
		rd_idx         = k_q;
		unique case (state_q)
			S_RDI: begin
				rd_idx = i_q;
			end
			S_RDJ: begin
				rd_idx     = j_q;
				cmd.cap_vi = 1'b1;
			end
			S_MULT: begin
				cmd.mul_en = 1'b1;
			end
			S_KLOOP: begin
				cmd.issue  = 1'b1;
				cmd.first  = k_lo;
				cmd.adj_ik = k_lo;
				cmd.adj_kj = k_hi;
			end
			S_WRITE: begin
				cmd.tbl_we = 1'b1;
			end
			S_DONE: begin
				cmd.score_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			nlast_q     <= '0;
			out_valid_q <= 1'b0;
			too_many_q  <= 1'b0;
		end else begin
			if (res_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (acc) begin
						if (in_last) begin
							count_q <= '0;
							if (n_new < NW'(3)) begin
								too_many_q <= ovf_q || !room;
								ovf_q      <= 1'b0;
							end else begin
								ovf_q   <= ovf_q || !room;
								nlast_q <= AW'(n_new - 1'b1);
								i_q     <= AW'(n_new - NW'(3));
								j_q     <= AW'(n_new - 1'b1);
								state_q <= S_RDI;
							end
						end else if (room) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				S_RDI: begin
					state_q <= S_RDJ;
				end
				S_RDJ: begin
					state_q <= S_MULT;
				end
				S_MULT: begin
					k_q     <= AW'(i_q + 1'b1);
					state_q <= S_KLOOP;
				end
				S_KLOOP: begin
					if (k_hi) begin
						state_q <= S_DRAIN1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DRAIN1: begin
					state_q <= S_DRAIN2;
				end
				S_DRAIN2: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (j_q == nlast_q) begin
						if (i_q == '0) begin
							state_q <= S_DONE;
						end else begin
							i_q     <= i_q - 1'b1;
							j_q     <= AW'(i_q + 1'b1);
							state_q <= S_RDI;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_RDI;
					end
				end
				S_DONE: begin
					if (out_free) begin
						too_many_q <= ovf_q;
						ovf_q      <= 1'b0;
						state_q    <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign too_many  = too_many_q;
	assign wr_idx    = count_q[AW-1:0];
	assign idx_i     = i_q;
	assign idx_j     = j_q;
	assign idx_k     = k_q;

endmodule

>>> src/min_score_polygon_triangulation.sv
// min_score_polygon_triangulation: top level, controller plus datapath
// depends on mspt_pkg, mspt_if, mspt_ctrl, mspt_datapath
//
// vertex weights arrive one per transaction on vertices, in polygon order; the
// transaction with last set closes the polygon. up to MAX_VERTICES weights are
// kept (only the low VALUE_BITS bits count), later ones are dropped and flagged
// in too_many. one result transaction on results follows each last vertex:
// score is the minimum triangulation cost, 0 below three vertices, and
// saturates at all ones if it ever exceeds 32 bits. vertices are taken back to
// back while loading. for n >= 3 stored vertices the interval sweep then runs
// one split point k per cycle through the multiply / add / min pipeline,
// which reads two interval table entries per cycle; each table entry also
// needs vertex fetch, product set-up, pipeline drain and write-back. no
// vertices are taken during the sweep. a finished result sits in an output
// register; while it waits to be taken no vertex is taken either, and the
// input opens again in the cycle the result is taken.
// no clearing pass is needed after reset; every table entry is written before
// it is read within a sweep.
module min_score_polygon_triangulation #(
	parameter int MAX_VERTICES = mspt_pkg::DEF_MAX_VERTICES,
	parameter int VALUE_BITS   = mspt_pkg::DEF_VALUE_BITS
) (
	input logic         clk,
	input logic         arst_n,
	mspt_in_if.sink     vertices,
	mspt_out_if.source  results
);
	import mspt_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);

	cmd_t          cmd;
	logic [AW-1:0] wr_idx, rd_idx, idx_i, idx_j, idx_k;

	// sequencer: load count, loop indices i, j, k and the result handshake
	mspt_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vertices.valid),
		.in_last   (vertices.last),
		.in_ready  (vertices.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.too_many  (results.too_many),
		.cmd       (cmd),
		.wr_idx    (wr_idx),
		.rd_idx    (rd_idx),
		.idx_i     (idx_i),
		.idx_j     (idx_j),
		.idx_k     (idx_k)
	);

	// stores and the min-plus pipeline
	mspt_datapath #(
		.MAX_VERTICES(MAX_VERTICES),
		.VALUE_BITS  (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.vertex_value (vertices.vertex_value),
		.wr_idx       (wr_idx),
		.rd_idx       (rd_idx),
		.idx_i        (idx_i),
		.idx_j        (idx_j),
		.idx_k        (idx_k),
		.score        (results.score)
	);

	// a stalled result keeps the input side closed
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |-> !vertices.ready)
		else $error("vertex taken while result stalled");

	// table write-back only after the last split point has left the pipeline
	a_write_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tbl_we |-> $past(cmd.issue, 3))
		else $error("table write before pipeline drain");

	// no vertex transaction while the sweep writes the table
	a_no_load_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tbl_we |-> !vertices.ready)
		else $error("input open during sweep");

	// short polygons give a zero score in the next cycle
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.score_zero |=> results.valid && (results.score == '0))
		else $error("short polygon score not zero");

endmodule

>>> tb/sv/mspt_tb_pkg.sv
// mspt_tb_pkg: scoreboard class for the min-score polygon triangulation bench
// holds its own vertex store and interval table; depends on mspt_pkg
package mspt_tb_pkg;
	import mspt_pkg::*;

	localparam int MAX_VERTICES = DEF_MAX_VERTICES;
	localparam logic [VERTEX_W-1:0] VALUE_MASK = VERTEX_W'((1 << DEF_VALUE_BITS) - 1);
	localparam longint unsigned SCORE_CEILING = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               too_many;
	} triangulation_result_t;

	class triangulation_scoreboard;
		logic [VERTEX_W-1:0]   weights [MAX_VERTICES];
		longint unsigned       cost [MAX_VERTICES][MAX_VERTICES];
		int unsigned           stored;
		bit                    overflowed;
		triangulation_result_t pending_scores [$];
		int unsigned           mismatches;
		int unsigned           vertices_noted;
		int unsigned           vertices_dropped;
		int unsigned           polygons_closed;
		int unsigned           results_checked;

		function new();
			stored = 0;
			overflowed = 0;
			mismatches = 0;
			vertices_noted = 0;
			vertices_dropped = 0;
			polygons_closed = 0;
			results_checked = 0;
		endfunction

		// accepted vertex transaction; a last vertex runs the interval sweep
		function void note_vertex(logic [VERTEX_W-1:0] value, logic is_last);
			triangulation_result_t res;
			longint unsigned       best;
			longint unsigned       cand;
			longint unsigned       prod;
			int                    n;
			int                    i;
			int                    j;
			int                    k;
			vertices_noted++;
			if (stored < MAX_VERTICES) begin
				weights[stored] = value & VALUE_MASK;
				stored++;
			end else begin
				overflowed = 1'b1;
				vertices_dropped++;
			end
			if (!is_last)
				return;
			n = stored;
			res.score = '0;
			if (n >= 3) begin
				for (i = n - 1; i >= 0; i--) begin
					if (i + 1 < n)
						cost[i][i + 1] = 0;
					for (j = i + 2; j < n; j++) begin
						best = '1;
						prod = 64'(weights[i]) * 64'(weights[j]);
						for (k = i + 1; k < j; k++) begin
							cand = prod * 64'(weights[k]) + cost[i][k] + cost[k][j];
							if (cand < best)
								best = cand;
						end
						cost[i][j] = best;
					end
				end
				res.score = (cost[0][n - 1] > SCORE_CEILING) ? '1 : cost[0][n - 1][SCORE_W-1:0];
			end
			res.too_many = overflowed;
			pending_scores.push_back(res);
			polygons_closed++;
			stored = 0;
			overflowed = 1'b0;
		endfunction

		function int unsigned outstanding();
			return pending_scores.size();
		endfunction

		task report(string msg);
			mismatches++;
			$display("mismatch: %s", msg);
		endtask

		// accepted result transaction, compared with the oldest expectation
		task check_result(logic [SCORE_W-1:0] score, logic too_many);
			triangulation_result_t want;
			if (pending_scores.size() == 0) begin
				report($sformatf("result with nothing expected: score=%0d too_many=%0b",
					score, too_many));
				return;
			end
			want = pending_scores.pop_front();
			results_checked++;
			if (score !== want.score)
				report($sformatf("result %0d score got %0d want %0d",
					results_checked, score, want.score));
			if (too_many !== want.too_many)
				report($sformatf("result %0d too_many got %0b want %0b",
					results_checked, too_many, want.too_many));
		endtask
	endclass

endpackage

>>> tb/sv/testbench.sv
// testbench: top of the min-score polygon triangulation bench
// drives vertex transactions, checks result transactions against the scoreboard
// depends on mspt_pkg, mspt_if, mspt_tb_pkg and the block under test
module testbench;
	import mspt_pkg::*;
	import mspt_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// a full 64-vertex sweep is the longest item to run; the directed part and the
	// random part hold one such sweep each, while the rest are small polygons,
	// so a correct run stays well under CYCLE_LIMIT even with every stall
	localparam int CYCLE_LIMIT    = 2_000_000;
	localparam int RANDOM_ITEMS   = 360;
	localparam int DRAIN_CYCLES   = 100;

	logic clk = 1'b0;
	logic arst_n;

	mspt_in_if  vertices_if ();
	mspt_out_if results_if ();

	min_score_polygon_triangulation u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.vertices (vertices_if),
		.results  (results_if)
	);

	triangulation_scoreboard sb = new();

	int unsigned cycle_count = 0;
	int unsigned tx_idle_pct = 24;
	int unsigned rx_idle_pct = 55;
	int unsigned random_sent = 0;
	bit          long_polygon_done = 0;

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// every input known from time zero
	initial begin
		arst_n = 1'b0;
		vertices_if.valid = 1'b0;
		vertices_if.vertex_value = '0;
		vertices_if.last = 1'b0;
		results_if.ready = 1'b0;
	end

	// result side stalls at random, changed at the falling edge only
	always @(negedge clk) begin
		results_if.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// result transactions sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready)
			sb.check_result(results_if.score, results_if.too_many);
	end

	// watchdog: a hung sweep or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.outstanding());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one vertex transaction; entered and left at a falling edge, valid stays
	// high on return so back-to-back transactions need no extra assignment
	task send_vertex(logic [VERTEX_W-1:0] value, logic is_last);
		while ($urandom_range(99) < tx_idle_pct) begin
			vertices_if.valid <= 1'b0;
			@(negedge clk);
		end
		vertices_if.valid <= 1'b1;
		vertices_if.vertex_value <= value;
		vertices_if.last <= is_last;
		do
			@(posedge clk);
		while (!vertices_if.ready);
		// accepted at this edge
		sb.note_vertex(value, is_last);
		@(negedge clk);
	endtask

	// polygon of random weights, extremes favored so that both ends of the
	// product range come up often
	task send_random_polygon(int unsigned n);
		int unsigned         r;
		logic [VERTEX_W-1:0] value;
		for (int unsigned i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 10)
				value = '0;
			else if (r < 20)
				value = '1;
			else
				value = VERTEX_W'($urandom_range(255));
			send_vertex(value, i == n - 1);
			random_sent++;
		end
	endtask

	initial begin
		int unsigned n;
		int unsigned r;

		// reset held from time zero, released at a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, first idle setting
		// lone vertex, then a two-vertex polygon: both score zero
		send_vertex(8'hFF, 1'b1);
		send_vertex(8'h00, 1'b0);
		send_vertex(8'hFF, 1'b1);
		// smallest real polygon at both value extremes
		send_vertex(8'hFF, 1'b0);
		send_vertex(8'hFF, 1'b0);
		send_vertex(8'hFF, 1'b1);
		send_vertex(8'h00, 1'b0);
		send_vertex(8'h00, 1'b0);
		send_vertex(8'h00, 1'b1);
		// square where the two diagonals cost very differently
		send_vertex(8'h01, 1'b0);
		send_vertex(8'hFF, 1'b0);
		send_vertex(8'h03, 1'b0);
		send_vertex(8'hC8, 1'b1);
		// pentagon with alternating bit patterns
		send_vertex(8'h55, 1'b0);
		send_vertex(8'hAA, 1'b0);
		send_vertex(8'h0F, 1'b0);
		send_vertex(8'hF0, 1'b0);
		send_vertex(8'h80, 1'b1);
		// store full: 64 heaviest vertices kept, two dropped, the last among
		// them, so the sweep runs over the stored ones with the flag set
		for (int i = 0; i < 66; i++)
			send_vertex((i < 64) ? 8'hFF : 8'h12, i == 65);
		// flag must be clear again on the next polygon
		send_vertex(8'h07, 1'b0);
		send_vertex(8'hFE, 1'b0);
		send_vertex(8'h01, 1'b1);

		// random part in three idle settings
		while (random_sent < RANDOM_ITEMS) begin
			case (random_sent * 3 / RANDOM_ITEMS)
				0: begin
					tx_idle_pct = 24;
					rx_idle_pct = 55;
				end
				1: begin
					tx_idle_pct = 55;
					rx_idle_pct = 24;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			// mostly small polygons keep the cubic sweep cheap
			r = $urandom_range(99);
			if (r < 80)
				n = $urandom_range(1, 10);
			else
				n = $urandom_range(11, 24);
			// one polygon exactly at capacity with random content
			if (!long_polygon_done && random_sent >= 200) begin
				n = MAX_VERTICES;
				long_polygon_done = 1;
			end
			send_random_polygon(n);
		end
		vertices_if.valid <= 1'b0;

		// wait for every expected result, then let the block settle
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d polygons from %0d vertex transactions, %0d dropped at capacity",
			sb.polygons_closed, sb.vertices_noted, sb.vertices_dropped);
		$display("%0d results checked, %0d mismatches, %0d cycles",
			sb.results_checked, sb.mismatches, cycle_count);
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
src/mspt_pkg.sv
src/mspt_if.sv
src/mspt_datapath.sv
src/mspt_ctrl.sv
src/min_score_polygon_triangulation.sv
tb/sv/mspt_tb_pkg.sv
tb/sv/testbench.sv
